FILE: rtl/core/dsc_pkg.sv
// drill sequencer package: state, action and motor command codes, result record
// no dependencies; used by the interfaces, the step logic and the top level
`default_nettype none

package dsc_pkg;

    // field widths
    localparam int ACTION_W = 4;
    localparam int STATE_W  = 3;
    localparam int MOTOR_W  = 2;
    localparam int TARGET_W = 24;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INIT           = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_HOME           = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_DRILL          = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_RETRACT        = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_RETRIEVE       = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_STOP_RETRIEVE  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAN          = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_STOP_CLEAN     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_TICK           = 4'd8;

    // sequencer state codes
    localparam logic [STATE_W-1:0] ST_UNKNOWN    = 3'd0;
    localparam logic [STATE_W-1:0] ST_READY      = 3'd1;
    localparam logic [STATE_W-1:0] ST_HOMING     = 3'd2;
    localparam logic [STATE_W-1:0] ST_DRILLING   = 3'd3;
    localparam logic [STATE_W-1:0] ST_RETRACTING = 3'd4;
    localparam logic [STATE_W-1:0] ST_RETRIEVING = 3'd5;
    localparam logic [STATE_W-1:0] ST_CLEANING   = 3'd6;

    // auger rotation codes
    localparam logic [MOTOR_W-1:0] TURN_NONE  = 2'd0;
    localparam logic [MOTOR_W-1:0] TURN_RIGHT = 2'd1;
    localparam logic [MOTOR_W-1:0] TURN_LEFT  = 2'd2;

    // press direction codes
    localparam logic [MOTOR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [MOTOR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [MOTOR_W-1:0] DIR_DOWN = 2'd2;

    // one result record: new state and the motor commands issued
    typedef struct packed {
        logic [STATE_W-1:0]  drill_state_out;
        logic                auger_soft_stop;
        logic [MOTOR_W-1:0]  auger_turn;
        logic                press_stop;
        logic [MOTOR_W-1:0]  press_direction;
        logic                press_target_valid;
        logic [TARGET_W-1:0] press_target;
        logic                press_set_home;
        logic                press_step;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/dsc_if.sv
// valid/ready channel interfaces for the drill sequencer input and result streams
// depends on dsc_pkg for field widths
`default_nettype none

interface dsc_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsc_pkg::ACTION_W-1:0]  action;
    logic                          upper_switch;

    modport source (output valid, output action, output upper_switch, input ready);
    modport sink   (input valid, input action, input upper_switch, output ready);
endinterface

interface dsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dsc_pkg::STATE_W-1:0]   drill_state_out;
    logic                          auger_soft_stop;
    logic [dsc_pkg::MOTOR_W-1:0]   auger_turn;
    logic                          press_stop;
    logic [dsc_pkg::MOTOR_W-1:0]   press_direction;
    logic                          press_target_valid;
    logic [dsc_pkg::TARGET_W-1:0]  press_target;
    logic                          press_set_home;
    logic                          press_step;

    modport source (
        output valid, output drill_state_out, output auger_soft_stop, output auger_turn,
        output press_stop, output press_direction, output press_target_valid,
        output press_target, output press_set_home, output press_step,
        input ready
    );
    modport sink (
        input valid, input drill_state_out, input auger_soft_stop, input auger_turn,
        input press_stop, input press_direction, input press_target_valid,
        input press_target, input press_set_home, input press_step,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/dsc_step.sv
// next-state and motor command logic for one transaction of the drill sequencer
// depends on dsc_pkg for codes and the result record
`default_nettype none

module dsc_step (
    input  wire logic [dsc_pkg::STATE_W-1:0]  i_state,
    input  wire logic [dsc_pkg::ACTION_W-1:0] i_action,
    input  wire logic                         i_upper_switch,
    input  wire logic [dsc_pkg::TARGET_W-1:0] i_drilling_target,
    output dsc_pkg::t_result                  o_result
);

    logic [dsc_pkg::STATE_W-1:0] st;

    // unreachable state code falls back to unknown
    always_comb begin
        if (i_state > dsc_pkg::ST_CLEANING) begin
            st = dsc_pkg::ST_UNKNOWN;
        end else begin
            st = i_state;
        end
    end

    // command decode, each command gated by its required state (init by the upper switch instead)
    always_comb begin
        o_result                 = '0;
        o_result.drill_state_out = st;
        unique case (i_action)
            dsc_pkg::ACT_INIT: begin
                if (i_upper_switch) begin
                    o_result.auger_soft_stop = 1'b1;
                    o_result.press_stop      = 1'b1;
                    o_result.drill_state_out = dsc_pkg::ST_READY;
                end
            end
            dsc_pkg::ACT_HOME: begin
                if (st == dsc_pkg::ST_UNKNOWN) begin
                    o_result.drill_state_out = dsc_pkg::ST_HOMING;
                    o_result.press_stop      = 1'b1;
                    o_result.auger_soft_stop = 1'b1;
                    o_result.press_direction = dsc_pkg::DIR_UP;
                end
            end
            dsc_pkg::ACT_DRILL: begin
                if (st == dsc_pkg::ST_READY) begin
                    o_result.drill_state_out    = dsc_pkg::ST_DRILLING;
                    o_result.auger_turn         = dsc_pkg::TURN_RIGHT;
                    o_result.press_target_valid = 1'b1;
                    o_result.press_target       = i_drilling_target;
                    o_result.press_direction    = dsc_pkg::DIR_DOWN;
                end
            end
            dsc_pkg::ACT_RETRACT: begin
                if (st == dsc_pkg::ST_DRILLING) begin
                    o_result.drill_state_out = dsc_pkg::ST_RETRACTING;
                    o_result.auger_soft_stop = 1'b1;
                    o_result.press_direction = dsc_pkg::DIR_UP;
                end
            end
            dsc_pkg::ACT_RETRIEVE: begin
                if (st == dsc_pkg::ST_READY) begin
                    o_result.drill_state_out = dsc_pkg::ST_RETRIEVING;
                    o_result.press_stop      = 1'b1;
                    o_result.auger_soft_stop = 1'b1;
                    o_result.auger_turn      = dsc_pkg::TURN_RIGHT;
                end
            end
            dsc_pkg::ACT_STOP_RETRIEVE: begin
                if (st == dsc_pkg::ST_RETRIEVING) begin
                    o_result.auger_soft_stop = 1'b1;
                    o_result.drill_state_out = dsc_pkg::ST_READY;
                end
            end
            dsc_pkg::ACT_CLEAN: begin
                if (st == dsc_pkg::ST_READY) begin
                    o_result.drill_state_out = dsc_pkg::ST_CLEANING;
                    o_result.press_stop      = 1'b1;
                    o_result.auger_soft_stop = 1'b1;
                    o_result.auger_turn      = dsc_pkg::TURN_LEFT;
                end
            end
            dsc_pkg::ACT_STOP_CLEAN: begin
                if (st == dsc_pkg::ST_CLEANING) begin
                    o_result.auger_soft_stop = 1'b1;
                    o_result.drill_state_out = dsc_pkg::ST_READY;
                end
            end
            dsc_pkg::ACT_TICK: begin
                // readiness check, homing/retraction end on the switch, drilling keeps stepping
                if (st == dsc_pkg::ST_UNKNOWN || st == dsc_pkg::ST_READY) begin
                    o_result.drill_state_out = i_upper_switch ? dsc_pkg::ST_READY
                                                              : dsc_pkg::ST_UNKNOWN;
                end else if (st == dsc_pkg::ST_HOMING) begin
                    if (i_upper_switch) begin
                        o_result.press_stop      = 1'b1;
                        o_result.press_set_home  = 1'b1;
                        o_result.drill_state_out = dsc_pkg::ST_READY;
                    end else begin
                        o_result.press_step = 1'b1;
                    end
                end else if (st == dsc_pkg::ST_DRILLING) begin
                    o_result.press_step = 1'b1;
                end else if (st == dsc_pkg::ST_RETRACTING) begin
                    if (i_upper_switch) begin
                        o_result.press_stop      = 1'b1;
                        o_result.drill_state_out = dsc_pkg::ST_READY;
                    end else begin
                        o_result.press_step = 1'b1;
                    end
                end
            end
            default: begin
                // unused action codes change nothing
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/drill_sequence_controller_core.sv
// drill sequencer top level: state and target registers, output register and skid stage
// depends on dsc_pkg, dsc_in_if / dsc_out_if and dsc_step
`default_nettype none

// Drill sequencer. Each input transaction (one action plus the upper end switch level)
// updates the sequencer state in the cycle it is accepted and yields exactly one registered
// result transaction. One transaction per cycle is sustained while input ready is high: the state
// update is a single pass of decode logic between the state register and the result register. The
// result side has an output register plus a one-entry skid stage, so input ready only drops once
// two results are waiting. The drilling target is to be written through i_cfg_we/i_cfg_data while
// no transaction is in flight; the block does not enforce this. It resets to zero.
module drill_sequence_controller_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    dsc_in_if.sink                            i_in,
    dsc_out_if.source                         o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [dsc_pkg::TARGET_W-1:0] i_cfg_data
);

    logic [dsc_pkg::STATE_W-1:0]  r_state;
    logic [dsc_pkg::TARGET_W-1:0] r_target;
    dsc_pkg::t_result             r_out;
    dsc_pkg::t_result             n_out;
    logic                         r_out_valid;
    logic                         n_out_valid;
    dsc_pkg::t_result             r_skid;
    logic                         r_skid_valid;
    logic                         n_skid_valid;
    dsc_pkg::t_result             step_res;
    logic                         in_fire;
    logic                         out_fire;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;
    assign out_fire   = r_out_valid && o_out.ready;

    // sequencer decode
    dsc_step u_step (
        .i_state           (r_state),
        .i_action          (i_in.action),
        .i_upper_switch    (i_in.upper_switch),
        .i_drilling_target (r_target),
        .o_result          (step_res)
    );

    // output register and skid stage steering
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_fire) begin
                n_out       = step_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_fire) begin
            n_skid_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dsc_pkg::ST_UNKNOWN;
            r_target     <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= step_res.drill_state_out;
            end
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_fire && r_out_valid && !o_out.ready) begin
            r_skid <= step_res;
        end
    end

    // result channel
    assign o_out.valid              = r_out_valid;
    assign o_out.drill_state_out    = r_out.drill_state_out;
    assign o_out.auger_soft_stop    = r_out.auger_soft_stop;
    assign o_out.auger_turn         = r_out.auger_turn;
    assign o_out.press_stop         = r_out.press_stop;
    assign o_out.press_direction    = r_out.press_direction;
    assign o_out.press_target_valid = r_out.press_target_valid;
    assign o_out.press_target       = r_out.press_target;
    assign o_out.press_set_home     = r_out.press_set_home;
    assign o_out.press_step         = r_out.press_step;

    // skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    // stalled output with a new transaction spills into the skid stage
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("result lost on stalled output");

    // state register never holds the unused code
    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= dsc_pkg::ST_CLEANING)
        else $error("sequencer state out of range");

    // target only shown together with its valid flag
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.press_target_valid) |-> (r_out.press_target == '0))
        else $error("press target nonzero without valid");

    // accepted transaction moves the state to the decoded next state
    a_state_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == $past(step_res.drill_state_out)))
        else $error("state register did not follow decode");

endmodule

`default_nettype wire
